@@ rtl/core/gasp_pkg.sv @@
`default_nettype none
package gasp_pkg;

  localparam int unsigned RowW      = 6;
  localparam int unsigned ColW      = 6;
  localparam int unsigned CellW     = RowW + ColW;
  localparam int unsigned NumCells  = 1 << CellW;
  localparam int unsigned CntW      = CellW + 1;
  localparam int unsigned DimW      = 7;
  localparam int unsigned MaxRows   = 1 << RowW;
  localparam int unsigned MaxCols   = 1 << ColW;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned GW        = CellW;
  localparam int unsigned FW        = 21;
  localparam int unsigned HW        = 15;
  localparam int unsigned KeyW      = FW + CellW;
  localparam int unsigned HeapAw    = 12;
  localparam int unsigned HeapDepth = 1 << HeapAw;
  localparam int unsigned SqSumW    = 13;
  localparam int unsigned SqVW      = 30;
  localparam int unsigned SqIters   = SqVW / 2;
  localparam int unsigned SqItW     = 4;

  localparam logic [1:0] OpWrite  = 2'd0;
  localparam logic [1:0] OpSearch = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoPath   = 3'd1;
  localparam logic [2:0] StReject   = 3'd2;
  localparam logic [2:0] StOverflow = 3'd3;
  localparam logic [2:0] StRange    = 3'd4;

  localparam logic [1:0] DirN = 2'd0;
  localparam logic [1:0] DirW = 2'd1;
  localparam logic [1:0] DirS = 2'd2;
  localparam logic [1:0] DirE = 2'd3;

  localparam logic CfgRows = 1'b0;
  localparam logic CfgCols = 1'b1;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [RowW-1:0] cell_row;
    logic [ColW-1:0] cell_col;
    logic            walkable;
    logic [RowW-1:0] goal_row;
    logic [ColW-1:0] goal_col;
    logic [11:0]     step_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [12:0]     path_length;
    logic [RowW-1:0] step_row;
    logic [ColW-1:0] step_col;
  } out_item_t;

  typedef struct packed {
    logic          closed;
    logic          seen;
    logic [FW-1:0] best;
    logic [GW-1:0] steps;
    logic [1:0]    dir;
  } cell_rec_t;

  typedef enum logic [1:0] {
    HeapClear = 2'd0,
    HeapPush  = 2'd1,
    HeapPop   = 2'd2
  } heap_op_e;

  typedef struct packed {
    logic            valid;
    heap_op_e        op;
    logic [KeyW-1:0] key;
  } heap_req_t;

  typedef struct packed {
    logic            done;
    logic            empty;
    logic            full;
    logic [KeyW-1:0] key;
  } heap_rsp_t;

  // step back along the stored move; off the array falls back to the source
  function automatic logic [CellW-1:0] parent_cell(input logic [CellW-1:0] node,
                                                   input logic [1:0] dir,
                                                   input logic [CellW-1:0] src);
    logic [RowW-1:0] r;
    logic [ColW-1:0] c;
    logic [CellW-1:0] p;
    r = node[CellW-1:ColW];
    c = node[ColW-1:0];
    p = src;
    unique case (dir)
      DirN: if (r != RowW'(MaxRows - 1)) p = {r + RowW'(1), c};
      DirW: if (c != ColW'(MaxCols - 1)) p = {r, c + ColW'(1)};
      DirS: if (r != '0) p = {r - RowW'(1), c};
      DirE: if (c != '0) p = {r, c - ColW'(1)};
      default: p = src;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/gasp_isqrt.sv @@
`default_nettype none
module gasp_isqrt import gasp_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [RowW-1:0] dr_i,
  input  wire logic [ColW-1:0] dc_i,
  output logic                 done_o,
  output logic [HW-1:0]        root_o
);

  logic [SqVW-1:0] v_q, v_d, r_q, r_d, b_q, b_d, rb;
  logic [SqItW-1:0] it_q, it_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [SqSumW-1:0] sum;

  assign sum = SqSumW'(dr_i * dr_i) + SqSumW'(dc_i * dc_i);
  assign rb  = r_q + b_q;

  always_comb begin
    v_d    = v_q;
    r_d    = r_q;
    b_d    = b_q;
    it_d   = it_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = SqVW'({sum, {(2 * FracBits){1'b0}}});
      r_d    = '0;
      b_d    = SqVW'(1) << (SqVW - 2);
      it_d   = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (v_q >= rb) begin
        v_d = v_q - rb;
        r_d = (r_q >> 1) + b_q;
      end else begin
        r_d = r_q >> 1;
      end
      b_d  = b_q >> 2;
      it_d = it_q + SqItW'(1);
      if (it_q == SqItW'(SqIters - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      it_q   <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[HW-1:0];

endmodule
`default_nettype wire

@@ rtl/core/gasp_heap.sv @@
`default_nettype none
module gasp_heap import gasp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire heap_req_t req_i,
  output heap_rsp_t rsp_o
);

  typedef enum logic [7:0] {
    HIdle    = 8'b00000001,
    HPopTop  = 8'b00000010,
    HPopLast = 8'b00000100,
    HSdChk   = 8'b00001000,
    HSdL     = 8'b00010000,
    HSdR     = 8'b00100000,
    HSuW     = 8'b01000000,
    HSuTop   = 8'b10000000
  } heap_state_e;

  localparam int unsigned IdxW = HeapAw + 2;

  logic [KeyW-1:0] heap_mem [HeapDepth];
  logic [KeyW-1:0] rd_q;

  heap_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [HeapAw-1:0] k_q, k_d, raddr, waddr, par;
  logic [KeyW-1:0] hole_q, hole_d, top_q, top_d, lkey_q, lkey_d, wdata, best;
  logic re, we, done, su_chk;
  logic [IdxW-1:0] lidx, ridx, cnt_x;

  assign lidx  = {1'b0, k_q, 1'b1};
  assign ridx  = lidx + IdxW'(1);
  assign cnt_x = IdxW'(cnt_q);
  assign par   = (k_q - HeapAw'(1)) >> 1;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    hole_d  = hole_q;
    top_d   = top_q;
    lkey_d  = lkey_q;
    re      = 1'b0;
    raddr   = '0;
    we      = 1'b0;
    waddr   = k_q;
    wdata   = hole_q;
    done    = 1'b0;
    su_chk  = 1'b0;
    best    = hole_q;
    unique case (state_q)
      HIdle: begin
        if (req_i.valid) begin
          unique case (req_i.op)
            HeapClear: begin
              cnt_d = '0;
              done  = 1'b1;
            end
            HeapPush: begin
              if (cnt_q == CntW'(HeapDepth)) begin
                done = 1'b1;
              end else begin
                k_d    = cnt_q[HeapAw-1:0];
                cnt_d  = cnt_q + CntW'(1);
                hole_d = req_i.key;
                su_chk = 1'b1;
              end
            end
            HeapPop: begin
              re      = 1'b1;
              raddr   = '0;
              state_d = HPopTop;
            end
            default: done = 1'b1;
          endcase
        end
      end
      HPopTop: begin
        top_d = rd_q;
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          done    = 1'b1;
          state_d = HIdle;
        end else begin
          re      = 1'b1;
          raddr   = cnt_d[HeapAw-1:0];
          state_d = HPopLast;
        end
      end
      HPopLast: begin
        hole_d  = rd_q;
        k_d     = '0;
        state_d = HSdChk;
      end
      HSdChk: begin
        if (lidx < cnt_x) begin
          re      = 1'b1;
          raddr   = lidx[HeapAw-1:0];
          state_d = HSdL;
        end else begin
          we      = 1'b1;
          done    = 1'b1;
          state_d = HIdle;
        end
      end
      HSdL: begin
        lkey_d = rd_q;
        if (ridx < cnt_x) begin
          re      = 1'b1;
          raddr   = ridx[HeapAw-1:0];
          state_d = HSdR;
        end else if (rd_q < hole_q) begin
          we      = 1'b1;
          wdata   = rd_q;
          k_d     = lidx[HeapAw-1:0];
          state_d = HSdChk;
        end else begin
          we      = 1'b1;
          done    = 1'b1;
          state_d = HIdle;
        end
      end
      HSdR: begin
        k_d = k_q;
        if (lkey_q < best) begin
          best = lkey_q;
          k_d  = lidx[HeapAw-1:0];
        end
        if (rd_q < best) begin
          best = rd_q;
          k_d  = ridx[HeapAw-1:0];
        end
        we    = 1'b1;
        wdata = best;
        if (k_d == k_q) begin
          done    = 1'b1;
          state_d = HIdle;
        end else begin
          state_d = HSdChk;
        end
      end
      HSuW: begin
        we = 1'b1;
        if (hole_q < rd_q) begin
          wdata  = rd_q;
          k_d    = par;
          su_chk = 1'b1;
        end else begin
          done    = 1'b1;
          state_d = HIdle;
        end
      end
      HSuTop: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = hole_q;
        done    = 1'b1;
        state_d = HIdle;
      end
      default: state_d = HIdle;
    endcase
    if (su_chk) begin
      if (k_d == '0) begin
        state_d = HSuTop;
      end else begin
        re      = 1'b1;
        raddr   = (k_d - HeapAw'(1)) >> 1;
        state_d = HSuW;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= heap_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    hole_q <= hole_d;
    top_q  <= top_d;
    lkey_q <= lkey_d;
  end

  assign rsp_o.done  = done;
  assign rsp_o.empty = (cnt_q == '0);
  assign rsp_o.full  = (cnt_q == CntW'(HeapDepth));
  assign rsp_o.key   = (state_q == HPopTop) ? rd_q : top_q;

endmodule
`default_nettype wire

@@ rtl/core/grid_astar_path_search.sv @@
// Search: a sweep clearing all 4096 cell records, then per expanded cell one heap
// pop with its sift-down, and per neighbour a run of the 15-step square root unit
// and, where the neighbour improves, a heap push with its sift-up.
// One item at a time. After reset a sweep over all 4096 map cells marks every cell
// blocked; no item is taken until it ends. Config writes are taken at any time.
`default_nettype none
module grid_astar_path_search import gasp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic      cfg_index_i,
  input  wire logic [DimW-1:0] cfg_data_i
);

  typedef enum logic [20:0] {
    SBoot    = 21'h000001,
    SIdle    = 21'h000002,
    SRdPath  = 21'h000004,
    SChkSrc  = 21'h000008,
    SChkGoal = 21'h000010,
    SClear   = 21'h000020,
    SInit    = 21'h000040,
    SInitW   = 21'h000080,
    SPop     = 21'h000100,
    SPopW    = 21'h000200,
    SCur     = 21'h000400,
    SNb      = 21'h000800,
    SNbRd    = 21'h001000,
    SSqrt    = 21'h002000,
    SCmp     = 21'h004000,
    SPushW   = 21'h008000,
    ST1A     = 21'h010000,
    ST1B     = 21'h020000,
    ST2A     = 21'h040000,
    ST2B     = 21'h080000,
    SResp    = 21'h100000
  } state_e;

  state_e state_q, state_d;

  logic walk_mem [NumCells];
  cell_rec_t rec_mem [NumCells];
  logic [CellW-1:0] path_mem [NumCells];
  logic walk_rd_q;
  cell_rec_t rec_rd_q;
  logic [CellW-1:0] path_rd_q;

  logic walk_we, walk_wd, walk_re, rec_we, rec_re, path_we, path_re;
  logic [CellW-1:0] walk_wa, walk_ra, rec_wa, rec_ra, path_wa, path_wd, path_ra;
  cell_rec_t rec_wd;

  logic [DimW-1:0] rows_q, cols_q, rows_eff, cols_eff;
  logic [RowW-1:0] src_r_q, goal_r_q, nb_r, cur_r, dr;
  logic [ColW-1:0] src_c_q, goal_c_q, nb_c, cur_c, dc;
  logic [CellW-1:0] src, goal, cur_q, cur_d, nb, nb_q, nb_d, t_q, t_d;
  logic [GW-1:0] cur_g_q, cur_g_d, g1;
  logic [1:0] x_q, x_d, gdir_q, gdir_d;
  logic [FW-1:0] f_q, f_d;
  logic tgoal_q, tgoal_d, nb_ok, sq_start, sq_done, advance;
  logic [HW-1:0] sq_root;
  logic [CntW-1:0] clr_q, clr_d, n_q, n_d, k_q, k_d, path_len_q, path_len_d;
  logic [2:0] status_q, status_d;
  logic [RowW-1:0] orow_q, orow_d;
  logic [ColW-1:0] ocol_q, ocol_d;
  logic out_valid_q, out_valid_d, accept;
  out_item_t out_data_q, out_data_d;
  heap_req_t heap_req;
  heap_rsp_t heap_rsp;

  gasp_heap u_heap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (heap_req),
    .rsp_o  (heap_rsp)
  );

  gasp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .dr_i    (dr),
    .dc_i    (dc),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= DimW'(MaxRows);
      cols_q <= DimW'(MaxCols);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRows: rows_q <= cfg_data_i;
        CfgCols: cols_q <= cfg_data_i;
        default: rows_q <= rows_q;
      endcase
    end
  end

  assign rows_eff = (rows_q == '0) ? DimW'(1) :
                    (rows_q > DimW'(MaxRows)) ? DimW'(MaxRows) : rows_q;
  assign cols_eff = (cols_q == '0) ? DimW'(1) :
                    (cols_q > DimW'(MaxCols)) ? DimW'(MaxCols) : cols_q;

  assign src   = {src_r_q, src_c_q};
  assign goal  = {goal_r_q, goal_c_q};
  assign cur_r = cur_q[CellW-1:ColW];
  assign cur_c = cur_q[ColW-1:0];
  assign g1    = cur_g_q + GW'(1);

  always_comb begin
    nb_r  = cur_r;
    nb_c  = cur_c;
    nb_ok = 1'b0;
    unique case (x_q)
      DirN: begin
        nb_ok = (cur_r != '0);
        nb_r  = cur_r - RowW'(1);
      end
      DirW: begin
        nb_ok = (cur_c != '0);
        nb_c  = cur_c - ColW'(1);
      end
      DirS: begin
        nb_ok = ({1'b0, cur_r} + DimW'(1)) < rows_eff;
        nb_r  = cur_r + RowW'(1);
      end
      DirE: begin
        nb_ok = ({1'b0, cur_c} + DimW'(1)) < cols_eff;
        nb_c  = cur_c + ColW'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign nb = {nb_r, nb_c};
  assign dr = (nb_r >= goal_r_q) ? nb_r - goal_r_q : goal_r_q - nb_r;
  assign dc = (nb_c >= goal_c_q) ? nb_c - goal_c_q : goal_c_q - nb_c;

  assign accept     = in_valid_i && (state_q == SIdle);
  assign in_stall_o = (state_q != SIdle);

  always_comb begin
    state_d     = state_q;
    walk_we     = 1'b0;
    walk_wa     = '0;
    walk_wd     = 1'b0;
    walk_re     = 1'b0;
    walk_ra     = '0;
    rec_we      = 1'b0;
    rec_wa      = '0;
    rec_wd      = '0;
    rec_re      = 1'b0;
    rec_ra      = '0;
    path_we     = 1'b0;
    path_wa     = '0;
    path_wd     = t_q;
    path_re     = 1'b0;
    path_ra     = '0;
    heap_req    = '0;
    sq_start    = 1'b0;
    advance     = 1'b0;
    clr_d       = clr_q;
    cur_d       = cur_q;
    cur_g_d     = cur_g_q;
    x_d         = x_q;
    nb_d        = nb_q;
    f_d         = f_q;
    gdir_d      = gdir_q;
    t_d         = t_q;
    tgoal_d     = tgoal_q;
    n_d         = n_q;
    k_d         = k_q;
    path_len_d  = path_len_q;
    status_d    = status_q;
    orow_d      = orow_q;
    ocol_d      = ocol_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      SBoot: begin
        walk_we = 1'b1;
        walk_wa = clr_q[CellW-1:0];
        clr_d   = clr_q + CntW'(1);
        if (clr_q == CntW'(NumCells - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (accept) begin
          status_d = StOk;
          orow_d   = '0;
          ocol_d   = '0;
          state_d  = SResp;
          unique case (in_data_i.opcode)
            OpWrite: begin
              walk_we = 1'b1;
              walk_wa = {in_data_i.cell_row, in_data_i.cell_col};
              walk_wd = in_data_i.walkable;
            end
            OpSearch: begin
              path_len_d   = '0;
              heap_req.valid = 1'b1;
              heap_req.op  = HeapClear;
              if (({1'b0, in_data_i.cell_row} >= rows_eff) ||
                  ({1'b0, in_data_i.cell_col} >= cols_eff) ||
                  ({1'b0, in_data_i.goal_row} >= rows_eff) ||
                  ({1'b0, in_data_i.goal_col} >= cols_eff)) begin
                status_d = StReject;
              end else begin
                walk_re = 1'b1;
                walk_ra = {in_data_i.cell_row, in_data_i.cell_col};
                state_d = SChkSrc;
              end
            end
            OpRead: begin
              if ({1'b0, in_data_i.step_index} < path_len_q) begin
                path_re = 1'b1;
                path_ra = in_data_i.step_index;
                state_d = SRdPath;
              end else begin
                status_d = StRange;
              end
            end
            default: status_d = StOk;
          endcase
        end
      end
      SRdPath: begin
        orow_d  = path_rd_q[CellW-1:ColW];
        ocol_d  = path_rd_q[ColW-1:0];
        state_d = SResp;
      end
      SChkSrc: begin
        if (!walk_rd_q) begin
          status_d = StReject;
          state_d  = SResp;
        end else begin
          walk_re = 1'b1;
          walk_ra = goal;
          state_d = SChkGoal;
        end
      end
      SChkGoal: begin
        if (!walk_rd_q || (src == goal)) begin
          status_d = StReject;
          state_d  = SResp;
        end else begin
          clr_d   = '0;
          state_d = SClear;
        end
      end
      SClear: begin
        rec_we = 1'b1;
        rec_wa = clr_q[CellW-1:0];
        clr_d  = clr_q + CntW'(1);
        if (clr_q == CntW'(NumCells - 1)) begin
          state_d = SInit;
        end
      end
      SInit: begin
        rec_we         = 1'b1;
        rec_wa         = src;
        rec_wd.seen    = 1'b1;
        heap_req.valid = 1'b1;
        heap_req.op    = HeapPush;
        heap_req.key   = {{FW{1'b0}}, src};
        state_d        = SInitW;
      end
      SInitW: begin
        if (heap_rsp.done) begin
          state_d = SPop;
        end
      end
      SPop: begin
        if (heap_rsp.empty) begin
          status_d = StNoPath;
          state_d  = SResp;
        end else begin
          heap_req.valid = 1'b1;
          heap_req.op    = HeapPop;
          state_d        = SPopW;
        end
      end
      SPopW: begin
        if (heap_rsp.done) begin
          cur_d   = heap_rsp.key[CellW-1:0];
          rec_re  = 1'b1;
          rec_ra  = heap_rsp.key[CellW-1:0];
          state_d = SCur;
        end
      end
      SCur: begin
        rec_we        = 1'b1;
        rec_wa        = cur_q;
        rec_wd        = rec_rd_q;
        rec_wd.closed = 1'b1;
        cur_g_d       = rec_rd_q.steps;
        x_d           = DirN;
        state_d       = SNb;
      end
      SNb: begin
        if (!nb_ok) begin
          advance = 1'b1;
        end else if (nb == goal) begin
          gdir_d  = x_q;
          t_d     = goal;
          tgoal_d = 1'b1;
          n_d     = CntW'(1);
          state_d = ST1A;
        end else begin
          walk_re  = 1'b1;
          walk_ra  = nb;
          rec_re   = 1'b1;
          rec_ra   = nb;
          sq_start = 1'b1;
          nb_d     = nb;
          state_d  = SNbRd;
        end
      end
      SNbRd: begin
        if (!rec_rd_q.closed && walk_rd_q) begin
          state_d = SSqrt;
        end else begin
          advance = 1'b1;
        end
      end
      SSqrt: begin
        if (sq_done) begin
          f_d     = FW'({g1, {FracBits{1'b0}}}) + FW'(sq_root);
          state_d = SCmp;
        end
      end
      SCmp: begin
        if (!rec_rd_q.seen || (rec_rd_q.best > f_q)) begin
          if (heap_rsp.full) begin
            status_d = StOverflow;
            state_d  = SResp;
          end else begin
            heap_req.valid = 1'b1;
            heap_req.op    = HeapPush;
            heap_req.key   = {f_q, nb_q};
            rec_we         = 1'b1;
            rec_wa         = nb_q;
            rec_wd.seen    = 1'b1;
            rec_wd.best    = f_q;
            rec_wd.steps   = g1;
            rec_wd.dir     = x_q;
            state_d        = SPushW;
          end
        end else begin
          advance = 1'b1;
        end
      end
      SPushW: begin
        if (heap_rsp.done) begin
          advance = 1'b1;
        end
      end
      ST1A: begin
        if ((t_q == src) || (n_q == CntW'(NumCells))) begin
          k_d     = n_q;
          t_d     = goal;
          tgoal_d = 1'b1;
          state_d = ST2A;
        end else if (tgoal_q) begin
          t_d     = parent_cell(t_q, gdir_q, src);
          tgoal_d = 1'b0;
          n_d     = n_q + CntW'(1);
        end else begin
          rec_re  = 1'b1;
          rec_ra  = t_q;
          state_d = ST1B;
        end
      end
      ST1B: begin
        t_d     = parent_cell(t_q, rec_rd_q.dir, src);
        n_d     = n_q + CntW'(1);
        state_d = ST1A;
      end
      ST2A: begin
        path_we = 1'b1;
        path_wa = CellW'(k_q - CntW'(1));
        k_d     = k_q - CntW'(1);
        if (k_q == CntW'(1)) begin
          path_len_d = n_q;
          status_d   = StOk;
          state_d    = SResp;
        end else if (tgoal_q) begin
          t_d     = parent_cell(t_q, gdir_q, src);
          tgoal_d = 1'b0;
        end else begin
          rec_re  = 1'b1;
          rec_ra  = t_q;
          state_d = ST2B;
        end
      end
      ST2B: begin
        t_d     = parent_cell(t_q, rec_rd_q.dir, src);
        state_d = ST2A;
      end
      SResp: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          out_data_d.status      = status_q;
          out_data_d.path_length = path_len_q;
          out_data_d.step_row    = orow_q;
          out_data_d.step_col    = ocol_q;
          state_d                = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
    if (advance) begin
      if (x_q == DirE) begin
        state_d = SPop;
      end else begin
        x_d     = x_q + 2'd1;
        state_d = SNb;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_we) begin
      walk_mem[walk_wa] <= walk_wd;
    end
    if (walk_re) begin
      walk_rd_q <= walk_mem[walk_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
    if (rec_re) begin
      rec_rd_q <= rec_mem[rec_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (path_we) begin
      path_mem[path_wa] <= path_wd;
    end
    if (path_re) begin
      path_rd_q <= path_mem[path_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SBoot;
      clr_q       <= '0;
      path_len_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      path_len_q  <= path_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_r_q  <= in_data_i.cell_row;
      src_c_q  <= in_data_i.cell_col;
      goal_r_q <= in_data_i.goal_row;
      goal_c_q <= in_data_i.goal_col;
    end
    cur_q      <= cur_d;
    cur_g_q    <= cur_g_d;
    x_q        <= x_d;
    nb_q       <= nb_d;
    f_q        <= f_d;
    gdir_q     <= gdir_d;
    t_q        <= t_d;
    tgoal_q    <= tgoal_d;
    n_q        <= n_d;
    k_q        <= k_d;
    status_q   <= status_d;
    orow_q     <= orow_d;
    ocol_q     <= ocol_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire
